// ===== hw/rtl/tsp_pkg.sv =====
// shared constants and phase codes for the trapezoid speed profile block
`default_nettype none
package tsp_pkg;
  localparam int SPD_W = 12;
  localparam int PH_W  = 2;
  localparam int Q_W   = 15;
  localparam int IDX_W = 2;

  localparam logic [PH_W-1:0] PH_ACCEL  = 2'd0;
  localparam logic [PH_W-1:0] PH_CRUISE = 2'd1;
  localparam logic [PH_W-1:0] PH_DECEL  = 2'd2;
  localparam logic [PH_W-1:0] PH_END    = 2'd3;

  localparam logic [IDX_W-1:0] CFG_RAMP_START = 2'd0;
  localparam logic [IDX_W-1:0] CFG_END_SPEED  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_TOP_SPEED  = 2'd2;

  localparam logic [SPD_W-1:0] RST_RAMP_START = 12'd20;
  localparam logic [SPD_W-1:0] RST_END_SPEED  = 12'd0;
  localparam logic [SPD_W-1:0] RST_TOP_SPEED  = 12'd380;
endpackage
`default_nettype wire

// ===== hw/rtl/tsp_if.sv =====
// valid/ready stream interfaces for the input and result channels
`default_nettype none
interface tsp_in_if #(parameter int POS_WIDTH = 23);
  logic                        valid;
  logic                        ready;
  logic signed [POS_WIDTH-1:0] seg_start_x;
  logic signed [POS_WIDTH-1:0] seg_start_y;
  logic signed [POS_WIDTH-1:0] goal_x;
  logic signed [POS_WIDTH-1:0] goal_y;
  logic signed [POS_WIDTH-1:0] now_x;
  logic signed [POS_WIDTH-1:0] now_y;
  modport source (output valid, seg_start_x, seg_start_y, goal_x, goal_y, now_x, now_y,
                  input ready);
  modport sink (input valid, seg_start_x, seg_start_y, goal_x, goal_y, now_x, now_y,
                output ready);
endinterface

interface tsp_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] speed_cmd;
  logic [1:0]  phase;
  modport source (output valid, speed_cmd, phase, input ready);
  modport sink (input valid, speed_cmd, phase, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/trapezoid_speed_profile.sv =====
// top level: two length pipelines, phase select, numerator, divider, output buffer
//
// Fully pipelined: one item per cycle, through POS_WIDTH + 31 register stages, the first
// loaded at the accepting edge (three stages of difference, square and sum, POS_WIDTH + 9
// square-root stages at one root bit each, phase, product and numerator stages, fifteen
// divider stages, then the two-entry output buffer). The rate is set by the pipeline
// enable, which drops only while the output buffer holds two results that have not
// been taken. The user must write registers through the cfg port only while the block
// is idle; the block itself does not enforce this.
`default_nettype none
module trapezoid_speed_profile
  import tsp_pkg::*;
#(
  parameter int POS_WIDTH = 23
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_idx,
  input  wire logic [SPD_W-1:0] cfg_wdata,
  tsp_in_if.sink                in_ch,
  tsp_out_if.source             out_ch
);
  localparam int LW = POS_WIDTH + 9;
  localparam int NW = LW + Q_W;

  logic [SPD_W-1:0] ramp_r, end_r, top_r;
  logic [1:0]       cnt_r;
  logic             en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_r <= RST_RAMP_START;
      end_r  <= RST_END_SPEED;
      top_r  <= RST_TOP_SPEED;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_RAMP_START: ramp_r <= cfg_wdata;
        CFG_END_SPEED:  end_r  <= cfg_wdata;
        CFG_TOP_SPEED:  top_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en          = cnt_r != 2'd2;
  assign in_ch.ready = en;

  logic          accept;
  logic          rv, tv;
  logic [LW-1:0] rem_l, tot_l;
  assign accept = in_ch.valid && en;

  tsp_len #(.PW(POS_WIDTH)) u_rem (
    .clk, .rst_n, .en, .in_vld(accept),
    .ax(in_ch.goal_x), .ay(in_ch.goal_y), .bx(in_ch.now_x), .by(in_ch.now_y),
    .out_vld(rv), .len(rem_l)
  );

  tsp_len #(.PW(POS_WIDTH)) u_tot (
    .clk, .rst_n, .en, .in_vld(accept),
    .ax(in_ch.goal_x), .ay(in_ch.goal_y), .bx(in_ch.seg_start_x), .by(in_ch.seg_start_y),
    .out_vld(tv), .len(tot_l)
  );

  // phase stage
  logic [LW-1:0]   off_c;
  logic [LW+2:0]   off6_c, tot4_c, tot1_c;
  logic [PH_W-1:0] ph_c;
  logic [LW-1:0]   tot_a_r, rem_a_r, off_a_r;
  logic [PH_W-1:0] ph_a_r;
  logic            va_r;

  assign off_c  = tot_l > rem_l ? tot_l - rem_l : rem_l - tot_l;
  assign off6_c = {1'b0, off_c, 2'b00} + {2'b00, off_c, 1'b0};
  assign tot4_c = {1'b0, tot_l, 2'b00};
  assign tot1_c = {3'b000, tot_l};

  always_comb begin
    if (tot_l == '0)          ph_c = PH_END;
    else if (off6_c < tot1_c) ph_c = PH_ACCEL;
    else if (off6_c < tot4_c) ph_c = PH_CRUISE;
    else if (off_c <= tot_l)  ph_c = PH_DECEL;
    else                      ph_c = PH_END;
  end

  // product stage
  logic signed [12:0]    dk_c;
  logic signed [15:0]    k_c;
  logic [13:0]           m_c, ma_c;
  logic [LW-1:0]         mb_c;
  logic signed [15:0]    kk_c;
  logic [LW+13:0]        p1_b_r;
  logic signed [LW+16:0] p2_b_r;
  logic [LW-1:0]         tot_b_r;
  logic [PH_W-1:0]       ph_b_r;
  logic                  vb_r;

  assign dk_c = $signed({1'b0, top_r}) - $signed({1'b0, ramp_r});
  assign k_c  = 16'(dk_c) * 16'sd6;
  assign m_c  = (top_r > end_r) ? 14'(top_r - end_r) * 14'd3 : 14'd0;

  always_comb begin
    ma_c = '0;
    mb_c = rem_a_r;
    kk_c = '0;
    case (ph_a_r)
      PH_ACCEL: begin
        ma_c = 14'(ramp_r);
        mb_c = tot_a_r;
        kk_c = k_c;
      end
      PH_DECEL: ma_c = m_c;
      default: ;
    endcase
  end

  // numerator stage
  logic signed [LW+17:0] nums_c;
  logic [NW-1:0]         num_c_r;
  logic [LW-1:0]         tot_c_r;
  logic [PH_W-1:0]       ph_c_r;
  logic                  vc_r;

  assign nums_c = $signed({4'b0000, p1_b_r}) + (LW+18)'(p2_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= rv && tv;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tot_a_r <= tot_l;
      rem_a_r <= rem_l;
      off_a_r <= off_c;
      ph_a_r  <= ph_c;
      p1_b_r  <= (LW+14)'(ma_c) * (LW+14)'(mb_c);
      p2_b_r  <= (LW+17)'(kk_c) * (LW+17)'($signed({1'b0, off_a_r}));
      tot_b_r <= tot_a_r;
      ph_b_r  <= ph_a_r;
      num_c_r <= nums_c[LW+17] ? '0 : NW'(nums_c);
      tot_c_r <= tot_b_r;
      ph_c_r  <= ph_b_r;
    end
  end

  logic            dv;
  logic [Q_W-1:0]  quo;
  logic [PH_W-1:0] dph;

  tsp_div #(.LW(LW)) u_div (
    .clk, .rst_n, .en, .in_vld(vc_r), .num(num_c_r), .den(tot_c_r), .in_phase(ph_c_r),
    .out_vld(dv), .quo, .out_phase(dph)
  );

  // speed select and output buffer
  logic [SPD_W-1:0] spd_c;
  always_comb begin
    case (dph)
      PH_END:    spd_c = '0;
      PH_CRUISE: spd_c = top_r;
      default:   spd_c = (quo > Q_W'(top_r)) ? top_r : quo[SPD_W-1:0];
    endcase
  end

  logic [SPD_W-1:0] spd0_r, spd1_r;
  logic [PH_W-1:0]  ph0_r, ph1_r;
  logic             push, pop;
  assign push = en && dv;
  assign pop  = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if ((push && cnt_r == 2'd1)) begin
        spd0_r <= spd_c;
        ph0_r  <= dph;
      end else begin
        spd0_r <= spd1_r;
        ph0_r  <= ph1_r;
        if (push) begin
          spd1_r <= spd_c;
          ph1_r  <= dph;
        end
      end
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        spd0_r <= spd_c;
        ph0_r  <= dph;
      end else begin
        spd1_r <= spd_c;
        ph1_r  <= dph;
      end
    end
  end

  assign out_ch.valid     = cnt_r != 2'd0;
  assign out_ch.speed_cmd = spd0_r;
  assign out_ch.phase     = ph0_r;

`ifndef SYNTHESIS
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.phase == PH_END |-> out_ch.speed_cmd == '0)
    else $error("end phase with nonzero speed");
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.speed_cmd <= top_r)
    else $error("speed above top speed");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output buffer overflow");
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 && !out_ch.ready |=> cnt_r == 2'd2 && !in_ch.ready)
    else $error("full buffer changed without a pop");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/tsp_len.sv =====
// pipelined euclidean length: abs diff, squares, sum, one root bit per stage
`default_nettype none
module tsp_len #(
  parameter int PW = 23
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_vld,
  input  wire logic signed [PW-1:0] ax,
  input  wire logic signed [PW-1:0] ay,
  input  wire logic signed [PW-1:0] bx,
  input  wire logic signed [PW-1:0] by,
  output logic                     out_vld,
  output logic [PW+8:0]            len
);
  localparam int RL  = PW + 9;
  localparam int RAD = 2 * RL;
  localparam int RMW = RL + 3;

  logic signed [PW:0] dx_c, dy_c;
  logic [PW-1:0]      dx_r, dy_r;
  logic [2*PW-1:0]    sqx_r, sqy_r;
  logic               v0_r, v1_r;

  logic [RAD-1:0] rad_r  [RL+1];
  logic [RMW-1:0] rem_r  [RL+1];
  logic [RL-1:0]  root_r [RL+1];
  logic           vld_r  [RL+1];

  assign dx_c = $signed({ax[PW-1], ax}) - $signed({bx[PW-1], bx});
  assign dy_c = $signed({ay[PW-1], ay}) - $signed({by[PW-1], by});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r      <= 1'b0;
      v1_r      <= 1'b0;
      vld_r[0]  <= 1'b0;
    end else if (en) begin
      v0_r      <= in_vld;
      v1_r      <= v0_r;
      vld_r[0]  <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r      <= dx_c[PW] ? PW'(-dx_c) : dx_c[PW-1:0];
      dy_r      <= dy_c[PW] ? PW'(-dy_c) : dy_c[PW-1:0];
      sqx_r     <= (2*PW)'(dx_r) * (2*PW)'(dx_r);
      sqy_r     <= (2*PW)'(dy_r) * (2*PW)'(dy_r);
      rad_r[0]  <= {1'b0, (2*PW+1)'(sqx_r) + (2*PW+1)'(sqy_r), 16'd0};
      rem_r[0]  <= '0;
      root_r[0] <= '0;
    end
  end

  for (genvar j = 0; j < RL; j++) begin : g_root
    logic [RMW-1:0] remx, trial;
    logic           ge;
    assign remx  = {rem_r[j][RMW-3:0], rad_r[j][RAD-1 -: 2]};
    assign trial = RMW'({root_r[j], 2'b01});
    assign ge    = remx >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else if (en) begin
        vld_r[j+1] <= vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[j+1]  <= rad_r[j] << 2;
        rem_r[j+1]  <= ge ? remx - trial : remx;
        root_r[j+1] <= {root_r[j][RL-2:0], ge};
      end
    end
  end

  assign out_vld = vld_r[RL];
  assign len     = root_r[RL];
endmodule
`default_nettype wire

// ===== hw/rtl/tsp_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module tsp_div
  import tsp_pkg::*;
#(
  parameter int LW = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_vld,
  input  wire logic [LW+Q_W-1:0] num,
  input  wire logic [LW-1:0]     den,
  input  wire logic [PH_W-1:0]   in_phase,
  output logic                   out_vld,
  output logic [Q_W-1:0]         quo,
  output logic [PH_W-1:0]        out_phase
);
  localparam int NW = LW + Q_W;

  logic [NW-1:0]   r_r  [Q_W+1];
  logic [LW-1:0]   d_r  [Q_W+1];
  logic [Q_W-1:0]  q_r  [Q_W+1];
  logic [PH_W-1:0] ph_r [Q_W+1];
  logic            v_r  [Q_W+1];

  always_comb begin
    r_r[0]  = num;
    d_r[0]  = den;
    q_r[0]  = '0;
    ph_r[0] = in_phase;
    v_r[0]  = in_vld;
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_step
    localparam int SH = Q_W - 1 - j;
    logic [NW-1:0] sh;
    logic          ge;
    assign sh = NW'(d_r[j]) << SH;
    assign ge = r_r[j] >= sh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j+1] <= 1'b0;
      end else if (en) begin
        v_r[j+1] <= v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[j+1]  <= ge ? r_r[j] - sh : r_r[j];
        d_r[j+1]  <= d_r[j];
        q_r[j+1]  <= {q_r[j][Q_W-2:0], ge};
        ph_r[j+1] <= ph_r[j];
      end
    end
  end

  assign out_vld   = v_r[Q_W];
  assign quo       = q_r[Q_W];
  assign out_phase = ph_r[Q_W];
endmodule
`default_nettype wire

// ===== verif/trapezoid_speed_profile_tb.sv =====
// self-checking testbench for trapezoid_speed_profile: random and directed segment queries
`default_nettype none
module trapezoid_speed_profile_tb;
  import tsp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POS_W = 23;
  localparam int Q_BITS = 6 * POS_W;
  localparam int LAT = POS_W + 40;
  localparam int STALL_LIMIT = 4000;
  localparam logic [IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef struct packed {
    pos_t sx, sy, gx, gy, nx, ny;
  } query_t;
  typedef struct packed {
    logic [SPD_W-1:0] speed;
    logic [PH_W-1:0]  ph;
  } speed_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_idx = '0;
  logic [SPD_W-1:0] cfg_wdata = '0;

  tsp_in_if #(.POS_WIDTH(POS_W)) in_ch ();
  tsp_out_if out_ch ();

  trapezoid_speed_profile #(.POS_WIDTH(POS_W)) u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  query_t query_q[$];
  speed_t speed_exp_q[$];
  logic [SPD_W-1:0] ramp_spd = RST_RAMP_START;
  logic [SPD_W-1:0] end_spd = RST_END_SPEED;
  logic [SPD_W-1:0] top_spd = RST_TOP_SPEED;
  int send_idle_pct = 37;
  int recv_idle_pct = 37;
  int recv_hold = 0;
  bit send_pause = 0;
  bit in_taken = 0;
  int n_sent = 0;
  int n_recv = 0;
  int n_err = 0;
  int n_phase[4] = '{0, 0, 0, 0};
  int quiet = 0;

  function automatic logic [63:0] isqrt(logic [127:0] v);
    logic [127:0] r, rem, trial;
    r = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 2) | ((v >> (2 * i)) & 128'd3);
      trial = (r << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        r = (r << 1) | 128'd1;
      end else begin
        r = r << 1;
      end
    end
    return r[63:0];
  endfunction

  function automatic logic [63:0] seg_len(pos_t ax, pos_t ay, pos_t bx, pos_t by);
    longint dx, dy;
    logic [127:0] sq;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    sq = 128'(dx * dx + dy * dy);
    return isqrt(sq << 16);
  endfunction

  function automatic speed_t profile_speed(query_t q);
    logic [63:0] rem, tot, off;
    longint spd, top, num;
    speed_t r;
    rem = seg_len(q.gx, q.gy, q.nx, q.ny);
    tot = seg_len(q.gx, q.gy, q.sx, q.sy);
    off = (tot > rem) ? tot - rem : rem - tot;
    top = longint'(top_spd);
    spd = 0;
    r.ph = PH_END;
    if (tot != 0) begin
      if (6 * off < tot) begin
        num = longint'(ramp_spd) * longint'(tot)
            + 6 * (top - longint'(ramp_spd)) * longint'(off);
        if (num < 0) num = 0;
        spd = num / longint'(tot);
        r.ph = PH_ACCEL;
      end else if (6 * off < 4 * tot) begin
        spd = top;
        r.ph = PH_CRUISE;
      end else if (off <= tot) begin
        if (top > longint'(end_spd))
          spd = (3 * (top - longint'(end_spd)) * longint'(rem)) / longint'(tot);
        r.ph = PH_DECEL;
      end
    end
    if (spd > top) spd = top;
    r.speed = spd[SPD_W-1:0];
    return r;
  endfunction

  // sender
  always @(negedge clk) begin
    logic hold;
    hold = in_ch.valid && !in_taken;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!hold) begin
      if (query_q.size() > 0 && !send_pause && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid       <= 1'b1;
        in_ch.seg_start_x <= query_q[0].sx;
        in_ch.seg_start_y <= query_q[0].sy;
        in_ch.goal_x      <= query_q[0].gx;
        in_ch.goal_y      <= query_q[0].gy;
        in_ch.now_x       <= query_q[0].nx;
        in_ch.now_y       <= query_q[0].ny;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // accept and check
  always @(posedge clk) begin
    query_t q;
    speed_t got, want;
    in_taken = 0;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      q = query_q.pop_front();
      speed_exp_q.push_back(profile_speed(q));
      in_taken = 1;
      n_sent++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.speed = out_ch.speed_cmd;
      got.ph = out_ch.phase;
      n_recv++;
      if (speed_exp_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("ERROR: unexpected beat speed=%0d phase=%0d",
                                  got.speed, got.ph);
      end else begin
        want = speed_exp_q.pop_front();
        n_phase[want.ph]++;
        if (got !== want) begin
          n_err++;
          if (n_err <= 10)
            $display("ERROR: beat %0d expected speed=%0d phase=%0d, got speed=%0d phase=%0d",
                     n_recv, want.speed, want.ph, got.speed, got.ph);
        end
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (query_q.size() == 0 && speed_exp_q.size() == 0))
      quiet <= 0;
    else
      quiet <= quiet + 1;
  end

  always @(posedge clk) begin
    if (quiet >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles", quiet);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic cfg_write(logic [IDX_W-1:0] idx, logic [SPD_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_RAMP_START) ramp_spd = val;
    else if (idx == CFG_END_SPEED) end_spd = val;
    else if (idx == CFG_TOP_SPEED) top_spd = val;
  endtask

  task automatic drain();
    wait (query_q.size() == 0 && speed_exp_q.size() == 0);
    repeat (LAT) @(posedge clk);
  endtask

  task automatic set_speeds(logic [SPD_W-1:0] r, logic [SPD_W-1:0] e, logic [SPD_W-1:0] t);
    drain();
    cfg_write(CFG_RAMP_START, r);
    cfg_write(CFG_END_SPEED, e);
    cfg_write(CFG_TOP_SPEED, t);
  endtask

  function automatic int spread(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic query_t rand_query();
    query_t q;
    int span, k, sx, sy, gx, gy;
    if ($urandom_range(9) < 2) begin
      q = Q_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom});
      return q;
    end
    span = 1 << $urandom_range(20, 1);
    sx = spread(1 << 20);
    sy = spread(1 << 20);
    gx = sx + spread(span);
    gy = sy + spread(span);
    if ($urandom_range(15) == 0) begin
      gx = sx;
      gy = sy;
    end
    k = $urandom_range(80);
    q.sx = pos_t'(sx);
    q.sy = pos_t'(sy);
    q.gx = pos_t'(gx);
    q.gy = pos_t'(gy);
    q.nx = pos_t'(sx + (gx - sx) * k / 64 + spread((span >> 6) + 1));
    q.ny = pos_t'(sy + (gy - sy) * k / 64 + spread((span >> 6) + 1));
    return q;
  endfunction

  task automatic push_query(int sx, int sy, int gx, int gy, int nx, int ny);
    query_t q;
    q.sx = pos_t'(sx); q.sy = pos_t'(sy); q.gx = pos_t'(gx); q.gy = pos_t'(gy);
    q.nx = pos_t'(nx); q.ny = pos_t'(ny);
    query_q.push_back(q);
  endtask

  task automatic push_random(int n);
    for (int i = 0; i < n; i++) query_q.push_back(rand_query());
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.seg_start_x = '0; in_ch.seg_start_y = '0;
    in_ch.goal_x = '0; in_ch.goal_y = '0;
    in_ch.now_x = '0; in_ch.now_y = '0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, each phase, zero segment, beyond end
    push_query(0, 0, 0, 0, 0, 0);
    push_query(-4194304, -4194304, 4194303, 4194303, -4194304, -4194304);
    push_query(-4194304, -4194304, 4194303, 4194303, 4194303, 4194303);
    push_query(4194303, 4194303, -4194304, -4194304, 4194303, -4194304);
    push_query(-4194304, 4194303, 4194303, -4194304, 0, 0);
    push_query(0, 0, 6000, 0, 500, 0);
    push_query(0, 0, 6000, 0, 2500, 0);
    push_query(0, 0, 6000, 0, 5000, 0);
    push_query(0, 0, 6000, 0, 6000, 0);
    push_query(0, 0, 6000, 0, 13000, 0);
    push_query(0, 0, 6000, 0, -8000, 0);
    push_query(0, 0, 6000, 0, 1000, 0);
    push_query(0, 0, 6000, 0, 4000, 0);
    push_query(100, 100, 100, 100, 4194303, -4194304);
    push_query(0, 0, 1, 1, 0, 0);
    push_query(-4194304, 0, 4194303, 0, -4194304, 0);
    push_query(0, 0, 0, 3, 0, 7);
    push_query(-5, -5, 4194303, -4194304, -5, -5);
    drain();

    push_random(300);
    set_speeds(12'd0, 12'd0, 12'd4095);
    recv_idle_pct = 0;
    send_idle_pct = 0;
    push_random(300);
    set_speeds(12'd4095, 12'd0, 12'd100);
    recv_idle_pct = 37;
    send_idle_pct = 37;
    push_random(150);
    wait (query_q.size() < 100);
    recv_hold = 500;
    wait (query_q.size() < 40);
    send_pause = 1;
    wait (speed_exp_q.size() == 0);
    send_pause = 0;
    push_random(150);
    set_speeds(12'd100, 12'd4095, 12'd200);
    cfg_write(CFG_SPARE, 12'd4095);
    push_random(300);
    set_speeds(12'd4095, 12'd4095, 12'd0);
    push_random(100);
    set_speeds(12'd0, 12'd4095, 12'd4095);
    push_random(100);
    set_speeds(12'($urandom), 12'($urandom), 12'($urandom));
    push_random(250);
    set_speeds(12'($urandom_range(200)), 12'($urandom_range(200)),
               12'($urandom_range(4095, 1000)));
    push_random(250);
    drain();

    $display("%0d queries sent, %0d results checked over 8 speed settings", n_sent, n_recv);
    $display("phases seen: accel %0d, cruise %0d, decel %0d, end %0d",
             n_phase[0], n_phase[1], n_phase[2], n_phase[3]);
    if (n_err == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", n_err);
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
